// ===== rtl/bia_pkg.sv =====
// Shared operation codes and control types for the bit-vector integer ALU.
package bia_pkg;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_EQ  = 4'd4;
  localparam logic [3:0] OP_NE  = 4'd5;
  localparam logic [3:0] OP_GT  = 4'd6;
  localparam logic [3:0] OP_LT  = 4'd7;
  localparam logic [3:0] OP_GE  = 4'd8;
  localparam logic [3:0] OP_LE  = 4'd9;

  localparam int unsigned OUT_W = 32;

  // Control that travels with each request down the back end
  typedef struct packed {
    logic vld;
    logic is_div;
    logic flag;
  } bia_ctl_t;

endpackage

// ===== rtl/bia_front.sv =====
// Front end: accepts requests, classifies the op and evaluates every op but divide.
module bia_front import bia_pkg::*; #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned CREDITS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [3:0]       in_op,
  input  logic [31:0]      in_lhs_value,
  input  logic [31:0]      in_rhs_value,
  input  logic             pop_acc,
  output bia_ctl_t         f_ctl,
  output logic [WIDTH-1:0] f_word,
  output logic [WIDTH-1:0] f_lhs,
  output logic [WIDTH-1:0] f_rhs
);

  localparam int unsigned CW = $clog2(CREDITS + 1);

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             acc;
  logic [WIDTH-1:0] a, b, d_ab, d_ba, word;
  logic             ge_ab, ge_ba, flag;
  bia_ctl_t         ctl_r;
  logic [WIDTH-1:0] word_r, lhs_r, rhs_r;

  // Credit count: requests taken but not yet popped
  assign in_full = (cnt_r == CW'(CREDITS));
  assign acc     = in_push && !in_full;

  always_comb begin
    cnt_nxt = cnt_r;
    if (acc && !pop_acc) cnt_nxt = cnt_r + 1'b1;
    else if (!acc && pop_acc) cnt_nxt = cnt_r - 1'b1;
  end

  // Operand sizing and the ge rule
  assign a     = WIDTH'(in_lhs_value);
  assign b     = WIDTH'(in_rhs_value);
  assign d_ab  = a - b;
  assign d_ba  = b - a;
  assign ge_ab = ~d_ab[WIDTH-1];
  assign ge_ba = ~d_ba[WIDTH-1];

  // Op decode
  always_comb begin
    word = '0;
    flag = 1'b0;
    case (in_op)
      OP_ADD: word = a + b;
      OP_SUB: word = d_ab;
      OP_MUL: word = WIDTH'(a * b);
      OP_DIV: word = '0;
      OP_EQ:  flag = ge_ab && ge_ba;
      OP_NE:  flag = !(ge_ab && ge_ba);
      OP_GT:  flag = !ge_ba;
      OP_LT:  flag = !ge_ab;
      OP_GE:  flag = ge_ab;
      OP_LE:  flag = ge_ba;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      ctl_r.vld <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      ctl_r.vld <= acc;
    end
    ctl_r.is_div <= (in_op == OP_DIV);
    ctl_r.flag   <= flag;
    word_r       <= word;
    lhs_r        <= a;
    rhs_r        <= b;
  end

  assign f_ctl  = ctl_r;
  assign f_word = word_r;
  assign f_lhs  = lhs_r;
  assign f_rhs  = rhs_r;

endmodule

// ===== rtl/bia_divpipe.sv =====
// Back end: restoring divider pipeline, one quotient bit per stage.
module bia_divpipe import bia_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bia_ctl_t         f_ctl,
  input  logic [WIDTH-1:0] f_word,
  input  logic [WIDTH-1:0] f_lhs,
  input  logic [WIDTH-1:0] f_rhs,
  output bia_ctl_t         b_ctl,
  output logic [WIDTH-1:0] b_word
);

  bia_ctl_t         ctl_r [0:WIDTH];
  logic [WIDTH-1:0] word_r [0:WIDTH];
  logic [WIDTH-1:0] dvd_r [0:WIDTH];
  logic [WIDTH-1:0] rem_r [0:WIDTH];
  logic [WIDTH-1:0] dsr_r [0:WIDTH];

  assign ctl_r[0]  = f_ctl;
  assign word_r[0] = f_word;
  assign dvd_r[0]  = f_lhs;
  assign rem_r[0]  = '0;
  assign dsr_r[0]  = f_rhs;

  for (genvar i = 0; i < WIDTH; i++) begin : g_stage
    logic [WIDTH:0]   rsh;
    logic [WIDTH+1:0] diff;
    logic             qb;

    // Shift in next dividend bit, try subtracting the divisor
    assign rsh  = {rem_r[i], dvd_r[i][WIDTH-1]};
    assign diff = {1'b0, rsh} - {2'b00, dsr_r[i]};
    assign qb   = ~diff[WIDTH+1];

    always_ff @(posedge clk) begin
      if (!rst_n) ctl_r[i+1].vld <= 1'b0;
      else        ctl_r[i+1].vld <= ctl_r[i].vld;
      ctl_r[i+1].is_div <= ctl_r[i].is_div;
      ctl_r[i+1].flag   <= ctl_r[i].flag;
      word_r[i+1]       <= word_r[i];
      dsr_r[i+1]        <= dsr_r[i];
      dvd_r[i+1]        <= {dvd_r[i][WIDTH-2:0], qb};
      rem_r[i+1]        <= qb ? diff[WIDTH-1:0] : rsh[WIDTH-1:0];
    end
  end

  assign b_ctl  = ctl_r[WIDTH];
  assign b_word = ctl_r[WIDTH].is_div ? dvd_r[WIDTH] : word_r[WIDTH];

endmodule

// ===== rtl/bia_outq.sv =====
// Result queue: memory plus output register presented on the pop side.
module bia_outq import bia_pkg::*; #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bia_ctl_t         b_ctl,
  input  logic [WIDTH-1:0] b_word,
  input  logic             out_pop,
  output logic             out_empty,
  output logic [31:0]      out_result_word,
  output logic             out_compare_flag,
  output logic             pop_acc
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [OUT_W:0]  mem [0:DEPTH-1];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r, cnt_nxt;
  logic            ov_r, load;
  logic [OUT_W:0]  o_r;

  assign pop_acc = out_pop && ov_r;
  assign load    = (cnt_r != '0) && (!ov_r || pop_acc);

  always_comb begin
    cnt_nxt = cnt_r;
    if (b_ctl.vld && !load) cnt_nxt = cnt_r + 1'b1;
    else if (!b_ctl.vld && load) cnt_nxt = cnt_r - 1'b1;
  end

  // Write side
  always_ff @(posedge clk) begin
    if (b_ctl.vld) mem[wp_r] <= {OUT_W'(b_word), b_ctl.flag};
  end

  // Registered read into the output register
  always_ff @(posedge clk) begin
    if (load) o_r <= mem[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (b_ctl.vld) wp_r <= wp_r + 1'b1;
      if (load) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
      if (load) ov_r <= 1'b1;
      else if (pop_acc) ov_r <= 1'b0;
    end
  end

  assign out_empty        = !ov_r;
  assign out_result_word  = o_r[OUT_W:1];
  assign out_compare_flag = o_r[0];

endmodule

// ===== rtl/bitvector_integer_alu.sv =====
// Top level of the bit-vector integer ALU with pipelined restoring divider.
// A push reaches the out_ ports through the front register, the WIDTH divider stages, the
// result queue write and the result queue read register; the path is the same for every op.
// Throughput: one request per cycle while in_full is low; the divider takes one bit per stage.
// Reset: synchronous active-low rst_n empties all queues; no clearing pass.
module bitvector_integer_alu import bia_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [3:0]  in_op,
  input  logic [31:0] in_lhs_value,
  input  logic [31:0] in_rhs_value,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [31:0] out_result_word,
  output logic        out_compare_flag
);

  localparam int unsigned DEPTH = 2 ** $clog2(WIDTH + 4);

  bia_ctl_t         f_ctl, b_ctl;
  logic [WIDTH-1:0] f_word, f_lhs, f_rhs, b_word;
  logic             pop_acc;

  bia_front #(.WIDTH(WIDTH), .CREDITS(DEPTH)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_op, .in_lhs_value, .in_rhs_value,
    .pop_acc, .f_ctl, .f_word, .f_lhs, .f_rhs
  );

  bia_divpipe #(.WIDTH(WIDTH)) u_div (
    .clk, .rst_n, .f_ctl, .f_word, .f_lhs, .f_rhs, .b_ctl, .b_word
  );

  bia_outq #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_outq (
    .clk, .rst_n, .b_ctl, .b_word, .out_pop, .out_empty, .out_result_word,
    .out_compare_flag, .pop_acc
  );

endmodule

// ===== rtl/bia_checker.sv =====
// Port-level checker for the ALU, bound to the top level.
module bia_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_pop,
  input logic        out_empty,
  input logic [31:0] out_result_word,
  input logic        out_compare_flag
);

  // Reset leaves both sides idle
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("not empty after reset");
  a_rst_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("full after reset");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_result_word)
      && $stable(out_compare_flag)))
    else $error("result changed while waiting");

  // A result with the compare flag set never carries a word
  a_flag_word: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_compare_flag) |-> (out_result_word == 32'd0))
    else $error("flag with nonzero word");

endmodule

bind bitvector_integer_alu bia_checker u_bia_checker (
  .clk, .rst_n, .in_full, .out_pop, .out_empty, .out_result_word, .out_compare_flag
);
